[hdl/i2cram_pkg.sv]
// Package for the I2C register access master: phase codes, operation codes,
// line segment decode and byte selection. Used by i2c_register_access_master_unit.
package i2cram_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_SEND  = 4'd2,
    PH_SACK  = 4'd3,
    PH_READ  = 4'd4,
    PH_RACK  = 4'd5,
    PH_STOP  = 4'd6
  } phase_t;

  localparam logic [1:0] OP_WRITE16 = 2'd0;
  localparam logic [1:0] OP_READ16  = 2'd1;
  localparam logic [1:0] OP_READ32  = 2'd2;

  localparam logic       KIND_CMD  = 1'b0;
  localparam logic       KIND_TICK = 1'b1;

  localparam logic [2:0] ACK_POLL_LIMIT    = 3'd5;
  localparam logic [6:0] DEVICE_CODE_RESET = 7'd84;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic scl;
    logic sda;
    logic chk_scl;
    logic chk_sda;
  } seg_t;

  function automatic logic [2:0] sends_total(input logic [1:0] op);
    return (op == OP_WRITE16) ? 3'd5 : 3'd3;
  endfunction

  function automatic logic [3:0] items_total(input logic [1:0] op);
    logic [3:0] t;
    case (op)
      OP_WRITE16: t = 4'd5;
      OP_READ16:  t = 4'd5;
      OP_READ32:  t = 4'd7;
      default:    t = 4'd5;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] byte_to_send(input logic [2:0]  idx,
                                              input logic [1:0]  op,
                                              input logic [6:0]  dev,
                                              input logic [15:0] addr,
                                              input logic [15:0] data);
    logic [7:0] b;
    case (idx)
      3'd0:    b = {dev, (op != OP_WRITE16)};
      3'd1:    b = addr[7:0];
      3'd2:    b = addr[15:8];
      3'd3:    b = data[7:0];
      default: b = data[15:8];
    endcase
    return b;
  endfunction

  // Drives and line checks for the half-period in progress.
  function automatic seg_t segment(input phase_t     ph,
                                   input logic [3:0] hc,
                                   input logic       send_bit,
                                   input logic       rack_bit);
    seg_t s;
    logic hi;
    hi = (hc == 4'd1) || (hc == 4'd2);
    s = '{scl: 1'b1, sda: 1'b1, chk_scl: 1'b0, chk_sda: 1'b0};
    case (ph)
      PH_START: begin
        if (hc < 4'd2) s = '{1'b1, 1'b1, 1'b1, 1'b1};
        else if (hc == 4'd2) s = '{1'b1, 1'b0, 1'b1, 1'b0};
        else s = '{1'b0, 1'b0, 1'b0, 1'b0};
      end
      PH_SEND: s = '{hi, send_bit, hi, hi & send_bit};
      PH_SACK, PH_READ: s = '{hi, 1'b1, hi, 1'b0};
      PH_RACK: s = '{hi, rack_bit, hi, 1'b0};
      PH_STOP: begin
        if (hc < 4'd2) s = '{1'b0, 1'b0, 1'b0, 1'b0};
        else if (hc == 4'd2) s = '{1'b1, 1'b0, 1'b1, 1'b0};
        else if (hc == 4'd3) s = '{1'b1, 1'b1, 1'b1, 1'b1};
        else if (hc < 4'd6) s = '{1'b0, 1'b1, 1'b0, 1'b0};
        else s = '{1'b1, 1'b1, 1'b1, 1'b1};
      end
      default: s = '{1'b1, 1'b1, 1'b0, 1'b0};
    endcase
    return s;
  endfunction

endpackage

[hdl/i2c_register_access_master_unit.sv]
// I2C register access master, one half-period per tick item.
// Depends on i2cram_pkg for phase codes and segment decode.
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tuser kind, tdata command and line samples
//  m_*      | out | m_tvalid/m_tready  | tdata line drives, status, read value
//  cfg_*    | in  | cfg_we             | cfg_data device code
//
// Every item yields one result via the input and result registers; one item per cycle unless m_tready stalls.
// An input register and a result register bound the single state update.
// The input register refills while a result waits, so a stalled output
// holds at most one result plus one item before s_tready drops.
// rst clears control state and sets device_code to 84.
module i2c_register_access_master_unit
  import i2cram_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [1:0] op, [17:2] target_addr, [33:18] write_data, [34] scl_in, [35] sda_in
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] kind
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
  // [35:4] read_data, [36] nacked, [37] aborted
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_data
);

  logic [6:0]  device_code;

  logic        in_valid;
  logic        in_kind;
  logic [1:0]  in_op;
  logic [15:0] in_addr;
  logic [15:0] in_wdata;
  logic        in_scl;
  logic        in_sda;
  logic        advance;

  phase_t      phase, phase_next;
  logic [1:0]  operation, operation_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [3:0]  half_count, half_count_next;
  logic [2:0]  ack_polls, ack_polls_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] address_hold, address_hold_next;
  logic [15:0] data_hold, data_hold_next;
  logic [31:0] read_accum, read_accum_next;
  logic        nack_sticky, nack_sticky_next;
  logic        scl_d, scl_d_next;
  logic        sda_d, sda_d_next;
  logic        done_next, abort_next;

  logic        out_valid;
  logic [OUT_DATA_W-1:0] out_data, out_data_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_code <= DEVICE_CODE_RESET;
    end else if (cfg_we) begin
      device_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= s_tuser;
      in_op    <= s_tdata[1:0];
      in_addr  <= s_tdata[17:2];
      in_wdata <= s_tdata[33:18];
      in_scl   <= s_tdata[34];
      in_sda   <= s_tdata[35];
    end
  end

  // Next state for one item.
  always_comb begin
    seg_t       seg_now;
    logic       rack_now;
    logic       go_next;
    logic [2:0] nb;
    logic [7:0] sb;
    logic [1:0] lane;

    phase_next        = phase;
    operation_next    = operation;
    byte_index_next   = byte_index;
    bit_index_next    = bit_index;
    half_count_next   = half_count;
    ack_polls_next    = ack_polls;
    shift_byte_next   = shift_byte;
    address_hold_next = address_hold;
    data_hold_next    = data_hold;
    read_accum_next   = read_accum;
    nack_sticky_next  = nack_sticky;
    done_next         = 1'b0;
    abort_next        = 1'b0;
    go_next           = 1'b0;
    nb                = byte_index;
    sb                = shift_byte;
    lane              = 2'(byte_index - 3'd3);

    rack_now = ({1'b0, byte_index} + 4'd1) >= items_total(operation);
    seg_now  = segment(phase, half_count, shift_byte[7], rack_now);

    if (in_kind == KIND_CMD) begin
      if (phase == PH_IDLE && in_op <= OP_READ32) begin
        operation_next    = in_op;
        address_hold_next = in_addr;
        data_hold_next    = in_wdata;
        read_accum_next   = '0;
        nack_sticky_next  = 1'b0;
        byte_index_next   = '0;
        bit_index_next    = '0;
        ack_polls_next    = '0;
        shift_byte_next   = '0;
        half_count_next   = '0;
        phase_next        = PH_START;
      end
    end else if (phase != PH_IDLE) begin
      if ((seg_now.chk_scl && !in_scl) || (seg_now.chk_sda && !in_sda)) begin
        phase_next      = PH_IDLE;
        half_count_next = '0;
        done_next       = 1'b1;
        abort_next      = 1'b1;
      end else begin
        case (phase)
          PH_START: begin
            if (half_count >= 4'd3) begin
              nb      = '0;
              go_next = 1'b1;
            end else begin
              half_count_next = half_count + 4'd1;
            end
          end
          PH_SEND: begin
            if (half_count >= 4'd3) begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              half_count_next = '0;
              if (bit_index == 3'd7) begin
                bit_index_next = '0;
                ack_polls_next = '0;
                phase_next     = PH_SACK;
              end else begin
                bit_index_next = bit_index + 3'd1;
              end
            end else begin
              half_count_next = half_count + 4'd1;
            end
          end
          PH_SACK: begin
            if (half_count == 4'd2) begin
              ack_polls_next = ack_polls + 3'd1;
              if (!in_sda) begin
                half_count_next = 4'd3;
              end else if (ack_polls_next >= ACK_POLL_LIMIT) begin
                nack_sticky_next = 1'b1;
                half_count_next  = 4'd3;
              end else begin
                half_count_next = 4'd1;
              end
            end else if (half_count >= 4'd3) begin
              nb      = byte_index + 3'd1;
              go_next = 1'b1;
            end else begin
              half_count_next = half_count + 4'd1;
            end
          end
          PH_READ: begin
            if (half_count == 4'd1) begin
              sb = {shift_byte[6:0], in_sda};
            end
            shift_byte_next = sb;
            if (half_count >= 4'd3) begin
              half_count_next = '0;
              if (bit_index == 3'd7) begin
                bit_index_next  = '0;
                read_accum_next = read_accum | ({24'd0, sb} << {lane, 3'b000});
                phase_next      = PH_RACK;
              end else begin
                bit_index_next = bit_index + 3'd1;
              end
            end else begin
              half_count_next = half_count + 4'd1;
            end
          end
          PH_RACK: begin
            if (half_count >= 4'd3) begin
              nb      = byte_index + 3'd1;
              go_next = 1'b1;
            end else begin
              half_count_next = half_count + 4'd1;
            end
          end
          default: begin
            if (half_count >= 4'd7) begin
              phase_next      = PH_IDLE;
              half_count_next = '0;
              done_next       = 1'b1;
            end else begin
              half_count_next = half_count + 4'd1;
            end
          end
        endcase

        if (go_next) begin
          byte_index_next = nb;
          half_count_next = '0;
          bit_index_next  = '0;
          if (nb < sends_total(operation)) begin
            shift_byte_next = byte_to_send(nb, operation, device_code,
                                           address_hold, data_hold);
            phase_next      = PH_SEND;
          end else if ({1'b0, nb} < items_total(operation)) begin
            shift_byte_next = '0;
            phase_next      = PH_READ;
          end else begin
            phase_next = PH_STOP;
          end
        end
      end
    end
  end

  // Line drives and result for one item.
  always_comb begin
    seg_t seg_after;
    logic rack_after;

    rack_after = ({1'b0, byte_index_next} + 4'd1) >= items_total(operation_next);
    seg_after  = segment(phase_next, half_count_next, shift_byte_next[7], rack_after);

    scl_d_next = scl_d;
    sda_d_next = sda_d;
    if (in_kind == KIND_CMD) begin
      if (phase == PH_IDLE && in_op <= OP_READ32) begin
        scl_d_next = 1'b1;
        sda_d_next = 1'b1;
      end
    end else if (phase != PH_IDLE) begin
      scl_d_next = seg_after.scl;
      sda_d_next = seg_after.sda;
    end

    out_data_next = {2'b00, abort_next, nack_sticky_next, read_accum_next, done_next,
                     (phase_next != PH_IDLE), sda_d_next, scl_d_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      operation    <= '0;
      byte_index   <= '0;
      bit_index    <= '0;
      half_count   <= '0;
      ack_polls    <= '0;
      shift_byte   <= '0;
      address_hold <= '0;
      data_hold    <= '0;
      read_accum   <= '0;
      nack_sticky  <= 1'b0;
      scl_d        <= 1'b1;
      sda_d        <= 1'b1;
    end else if (advance) begin
      phase        <= phase_next;
      operation    <= operation_next;
      byte_index   <= byte_index_next;
      bit_index    <= bit_index_next;
      half_count   <= half_count_next;
      ack_polls    <= ack_polls_next;
      shift_byte   <= shift_byte_next;
      address_hold <= address_hold_next;
      data_hold    <= data_hold_next;
      read_accum   <= read_accum_next;
      nack_sticky  <= nack_sticky_next;
      scl_d        <= scl_d_next;
      sda_d        <= sda_d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_abort_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[37] |-> out_data[3] && !out_data[2])
    else $error("abort result without done or with busy set");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data[2] |-> out_data[0] && out_data[1])
    else $error("idle result with a line pulled low");

  a_item_processed: assert property (@(posedge clk) disable iff (rst)
    in_valid && (!out_valid || m_tready) |=> out_valid)
    else $error("item advanced without a result");

  a_half_count_range: assert property (@(posedge clk) disable iff (rst)
    phase != PH_STOP |-> half_count < 4'd4)
    else $error("half period count out of range");
`endif

endmodule

[sim/i2c_register_access_master_unit_checker.sv]
`timescale 1ns / 100ps
// Checker for i2c_register_access_master_unit: tracks the bus sequencer, predicts every
// result item and compares it with the m_* channel. Depends on i2cram_pkg.
module i2c_register_access_master_unit_checker
  import i2cram_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // [1:0] op, [17:2] target_addr, [33:18] write_data, [34] scl_in, [35] sda_in
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] kind
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
  // [35:4] read_data, [36] nacked, [37] aborted
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_data,
  output int                    fail_count,
  output int                    outstanding,
  output phase_t                line_phase,
  output logic                  line_scl,
  output logic                  line_sda
);

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  op;
    logic [2:0]  byte_idx;
    logic [2:0]  bit_idx;
    logic [3:0]  hc;
    logic [2:0]  polls;
    logic [7:0]  shreg;
    logic [15:0] addr;
    logic [15:0] data;
    logic [31:0] accum;
    logic        nack;
    logic        scl_d;
    logic        sda_d;
    logic [6:0]  dev;
  } bus_state_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    logic [31:0] rdata;
    logic        nack;
    logic        abort;
  } bus_result_t;

  typedef struct packed {
    bus_state_t  s;
    bus_result_t r;
  } bus_step_t;

  bus_state_t  held;
  bus_state_t  pre;
  bus_state_t  after;
  bus_step_t   stepped;
  bus_result_t want;
  bus_result_t pending_q[$];

  function automatic bus_state_t fresh_bus();
    bus_state_t s;
    s = '0;
    s.phase = PH_IDLE;
    s.dev = DEVICE_CODE_RESET;
    s.scl_d = 1'b1;
    s.sda_d = 1'b1;
    return s;
  endfunction

  function automatic logic [3:0] sent_total(input logic [1:0] op);
    return (op == OP_WRITE16) ? 4'd5 : 4'd3;
  endfunction

  function automatic logic [3:0] xfer_total(input logic [1:0] op);
    return (op == OP_READ32) ? 4'd7 : 4'd5;
  endfunction

  function automatic logic [7:0] outgoing_byte(input bus_state_t s);
    logic [7:0] b;
    case (s.byte_idx)
      3'd0:    b = {s.dev, s.op != OP_WRITE16};
      3'd1:    b = s.addr[7:0];
      3'd2:    b = s.addr[15:8];
      3'd3:    b = s.data[7:0];
      default: b = s.data[15:8];
    endcase
    return b;
  endfunction

  // {scl, sda, check scl high, check sda high}
  function automatic logic [3:0] half_period_plan(input bus_state_t s);
    logic       up;
    logic       last_rx;
    logic [3:0] plan;
    up = (s.hc == 4'd1) || (s.hc == 4'd2);
    last_rx = ({1'b0, s.byte_idx} + 4'd1) >= xfer_total(s.op);
    case (s.phase)
      PH_START: begin
        if (s.hc < 4'd2) plan = 4'b1111;
        else if (s.hc == 4'd2) plan = 4'b1010;
        else plan = 4'b0000;
      end
      PH_SEND: plan = {up, s.shreg[7], up, up & s.shreg[7]};
      PH_SACK, PH_READ: plan = {up, 1'b1, up, 1'b0};
      PH_RACK: plan = {up, last_rx, up, 1'b0};
      PH_STOP: begin
        if (s.hc < 4'd2) plan = 4'b0000;
        else if (s.hc == 4'd2) plan = 4'b1010;
        else if (s.hc == 4'd3) plan = 4'b1111;
        else if (s.hc < 4'd6) plan = 4'b0100;
        else plan = 4'b1111;
      end
      default: plan = 4'b1100;
    endcase
    return plan;
  endfunction

  function automatic bus_state_t load_next_byte(input bus_state_t s);
    bus_state_t n;
    n = s;
    n.hc = 4'd0;
    n.bit_idx = 3'd0;
    if ({1'b0, s.byte_idx} < sent_total(s.op)) begin
      n.shreg = outgoing_byte(s);
      n.phase = PH_SEND;
    end else if ({1'b0, s.byte_idx} < xfer_total(s.op)) begin
      n.shreg = 8'd0;
      n.phase = PH_READ;
    end else begin
      n.phase = PH_STOP;
    end
    return n;
  endfunction

  function automatic bus_step_t advance_bus(input bus_state_t s, input logic kind,
                                            input logic [1:0] op, input logic [15:0] addr,
                                            input logic [15:0] wdata, input logic scl_in,
                                            input logic sda_in);
    bus_step_t  res;
    bus_state_t n;
    logic [3:0] plan;
    logic [2:0] lane;
    logic       done;
    logic       abort;
    n = s;
    done = 1'b0;
    abort = 1'b0;
    if (kind == KIND_CMD) begin
      if (s.phase == PH_IDLE && op <= OP_READ32) begin
        n.op = op;
        n.addr = addr;
        n.data = wdata;
        n.accum = 32'd0;
        n.nack = 1'b0;
        n.byte_idx = 3'd0;
        n.bit_idx = 3'd0;
        n.polls = 3'd0;
        n.shreg = 8'd0;
        n.hc = 4'd0;
        n.phase = PH_START;
        n.scl_d = 1'b1;
        n.sda_d = 1'b1;
      end
    end else if (s.phase != PH_IDLE) begin
      plan = half_period_plan(s);
      if ((plan[1] && !scl_in) || (plan[0] && !sda_in)) begin
        n.phase = PH_IDLE;
        n.hc = 4'd0;
        done = 1'b1;
        abort = 1'b1;
      end else begin
        case (s.phase)
          PH_START: begin
            n.hc = s.hc + 4'd1;
            if (n.hc >= 4'd4) begin
              n.byte_idx = 3'd0;
              n = load_next_byte(n);
            end
          end
          PH_SEND: begin
            if (s.hc >= 4'd3) begin
              n.shreg = {s.shreg[6:0], 1'b0};
              n.hc = 4'd0;
              if (s.bit_idx >= 3'd7) begin
                n.bit_idx = 3'd0;
                n.polls = 3'd0;
                n.phase = PH_SACK;
              end else n.bit_idx = s.bit_idx + 3'd1;
            end else n.hc = s.hc + 4'd1;
          end
          PH_SACK: begin
            if (s.hc == 4'd2) begin
              n.polls = s.polls + 3'd1;
              if (!sda_in) n.hc = 4'd3;
              else if (n.polls >= ACK_POLL_LIMIT) begin
                n.nack = 1'b1;
                n.hc = 4'd3;
              end else n.hc = 4'd1;
            end else if (s.hc >= 4'd3) begin
              n.byte_idx = s.byte_idx + 3'd1;
              n = load_next_byte(n);
            end else n.hc = s.hc + 4'd1;
          end
          PH_READ: begin
            if (s.hc == 4'd1) n.shreg = {s.shreg[6:0], sda_in};
            if (s.hc >= 4'd3) begin
              n.hc = 4'd0;
              if (s.bit_idx >= 3'd7) begin
                n.bit_idx = 3'd0;
                lane = s.byte_idx - 3'd3;
                n.accum = s.accum | ({24'd0, n.shreg} << {lane[1:0], 3'b000});
                n.phase = PH_RACK;
              end else n.bit_idx = s.bit_idx + 3'd1;
            end else n.hc = s.hc + 4'd1;
          end
          PH_RACK: begin
            if (s.hc >= 4'd3) begin
              n.byte_idx = s.byte_idx + 3'd1;
              n = load_next_byte(n);
            end else n.hc = s.hc + 4'd1;
          end
          default: begin
            if (s.hc >= 4'd7) begin
              n.phase = PH_IDLE;
              n.hc = 4'd0;
              done = 1'b1;
            end else n.hc = s.hc + 4'd1;
          end
        endcase
      end
      plan = half_period_plan(n);
      n.scl_d = plan[3];
      n.sda_d = plan[2];
    end
    res.s = n;
    res.r.scl = n.scl_d;
    res.r.sda = n.sda_d;
    res.r.busy = (n.phase != PH_IDLE);
    res.r.done = done;
    res.r.rdata = n.accum;
    res.r.nack = n.nack;
    res.r.abort = abort;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] seen,
                               input logic [31:0] predicted);
    $display("%0t: mismatch on %s: got %h, predicted %h", $time, field, seen, predicted);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always_comb begin
    pre = held;
    if (cfg_we) pre.dev = cfg_data;
    stepped = advance_bus(pre, s_tuser, s_tdata[1:0], s_tdata[17:2], s_tdata[33:18],
                          s_tdata[34], s_tdata[35]);
    after = (s_tvalid && s_tready) ? stepped.s : pre;
    if (rst) after = fresh_bus();
  end

  assign line_phase = after.phase;
  assign line_scl = after.scl_d;
  assign line_sda = after.sda_d;

  always @(posedge clk) begin
    held <= after;
    if (rst) begin
      pending_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          flag_mismatch("item without prediction", m_tdata[31:0], 32'd0);
        end else begin
          want = pending_q.pop_front();
          if (m_tdata[0] !== want.scl)
            flag_mismatch("scl_drive", 32'(m_tdata[0]), 32'(want.scl));
          if (m_tdata[1] !== want.sda)
            flag_mismatch("sda_drive", 32'(m_tdata[1]), 32'(want.sda));
          if (m_tdata[2] !== want.busy)
            flag_mismatch("busy_res", 32'(m_tdata[2]), 32'(want.busy));
          if (m_tdata[3] !== want.done)
            flag_mismatch("done_res", 32'(m_tdata[3]), 32'(want.done));
          if (m_tdata[35:4] !== want.rdata)
            flag_mismatch("read_data", m_tdata[35:4], want.rdata);
          if (m_tdata[36] !== want.nack)
            flag_mismatch("nacked", 32'(m_tdata[36]), 32'(want.nack));
          if (m_tdata[37] !== want.abort)
            flag_mismatch("aborted", 32'(m_tdata[37]), 32'(want.abort));
        end
      end
      if (s_tvalid && s_tready) pending_q.push_back(stepped.r);
    end
    outstanding <= pending_q.size();
  end

endmodule

[sim/i2c_register_access_master_unit_test.sv]
`timescale 1ns / 100ps
// Top of the i2c_register_access_master_unit bench: clock, reset, command and tick
// stimulus with a simple target model on the bus, verdict. Depends on i2cram_pkg and the checker.
module i2c_register_access_master_unit_test
  import i2cram_pkg::*;
();

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         PHASE_ITEMS = 200;
  localparam int         CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [6:0]            cfg_data = 7'd0;

  int     fail_count;
  int     outstanding;
  phase_t line_phase;
  logic   line_scl;
  logic   line_sda;

  int idle_pct = 0;
  int stall_pct = 0;
  int ack_pct = 100;
  int cycle_count = 0;
  int counted;
  int pick;
  logic [6:0] next_dev;

  i2c_register_access_master_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  i2c_register_access_master_unit_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .line_phase  (line_phase),
    .line_scl    (line_scl),
    .line_sda    (line_sda)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [1:0] op, input logic [15:0] addr,
                           input logic [15:0] wdata, input logic scl, input logic sda);
    s_tuser <= kind;
    s_tdata <= {4'd0, sda, scl, wdata, addr, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic sender_pause();
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic issue_command(input logic [1:0] op, input logic [15:0] addr,
                               input logic [15:0] wdata);
    int r;
    sender_pause();
    if (line_phase == PH_IDLE && op != OP_UNUSED) begin
      r = $urandom_range(0, 99);
      ack_pct = (r < 50) ? 100 : ((r < 85) ? 30 : 0);
    end
    send_item(KIND_CMD, op, addr, wdata, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // Target side: ack in the acknowledge slot, random data while the master reads.
  task automatic bus_tick(input bit noisy);
    logic scl;
    logic sda;
    sender_pause();
    scl = line_scl;
    sda = line_sda;
    case (line_phase)
      PH_SACK: if ($urandom_range(0, 99) < ack_pct) sda = 1'b0;
      PH_READ: sda = line_sda & 1'($urandom_range(0, 1));
      default: ;
    endcase
    if (noisy && $urandom_range(0, 999) == 0) scl = 1'b0;
    if (noisy && $urandom_range(0, 999) == 0) sda = 1'b0;
    send_item(KIND_TICK, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), scl, sda);
  endtask

  task automatic settle_and_configure(input logic [6:0] dev);
    while (line_phase != PH_IDLE) bus_tick(1'b0);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_data <= dev;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    settle_and_configure(7'd0);
    idle_pct = 25;
    stall_pct <= 25;

    send_item(KIND_TICK, OP_UNUSED, 16'hffff, 16'h0000, 1'b0, 1'b0);
    send_item(KIND_CMD, OP_UNUSED, 16'hffff, 16'hffff, 1'b1, 1'b1);
    issue_command(OP_WRITE16, 16'h0000, 16'hffff);
    send_item(KIND_CMD, OP_READ32, 16'h1234, 16'h5678, 1'b0, 1'b0);
    send_item(KIND_TICK, OP_WRITE16, 16'h0000, 16'h0000, 1'b1, 1'b0);
    issue_command(OP_READ16, 16'hffff, 16'h0000);
    bus_tick(1'b0);
    bus_tick(1'b0);
    send_item(KIND_TICK, OP_WRITE16, 16'h0000, 16'h0000, 1'b0, 1'b1);
    issue_command(OP_READ32, 16'h8000, 16'h0001);
    ack_pct = 100;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: next_dev = 7'd127;
        2: next_dev = DEVICE_CODE_RESET;
        default: next_dev = 7'($urandom_range(0, 127));
      endcase
      settle_and_configure(next_dev);
      case (p)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 51; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 51; end
        default: begin idle_pct = 25; stall_pct <= 25; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (line_phase == PH_IDLE) begin
          if (pick < 8) begin
            sender_pause();
            send_item(KIND_TICK, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end else if (pick < 12) begin
            issue_command(OP_UNUSED, 16'($urandom), 16'($urandom));
          end else begin
            issue_command(2'($urandom_range(OP_WRITE16, OP_READ32)), 16'($urandom),
                          16'($urandom));
            counted++;
          end
        end else if (pick < 2) begin
          issue_command(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        end else begin
          bus_tick(1'b1);
          counted++;
        end
      end
    end

    while (line_phase != PH_IDLE) bus_tick(1'b0);
    s_tvalid <= 1'b0;
    stall_pct <= 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
